>>> rtl/arq_pkg.sv
// Package for the ARQ sender with relay fallback.
// Holds phase, handler and send codes, the register map and the item types.
// No dependencies.
`timescale 1ns / 1ps

package arq_pkg;

  localparam int NumRegs   = 8;
  localparam int AddrWidth = 5;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    REG_RSSI_OFFSET   = 3'd0,
    REG_RSSI_THRESH   = 3'd1,
    REG_TMO_LIMIT     = 3'd2,
    REG_NACK_LIMIT    = 3'd3,
    REG_INIT_TIMEOUT  = 3'd4,
    REG_REST_TIMEOUT  = 3'd5,
    REG_PKTS_PER_SEQ  = 3'd6,
    REG_TOTAL_LIMIT   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_PROBE = 2'd1,
    PH_TX    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RH_NONE  = 2'd0,
    RH_TX    = 2'd1,
    RH_PROBE = 2'd2
  } rx_handler_t;

  typedef enum logic [1:0] {
    PR_NONE   = 2'd0,
    PR_WEAK   = 2'd1,
    PR_STRONG = 2'd2
  } probe_res_t;

  typedef enum logic [1:0] {
    SK_NONE  = 2'd0,
    SK_DATA  = 2'd1,
    SK_PROBE = 2'd2
  } send_kind_t;

  localparam logic [7:0]  RxAck        = 8'd1;
  localparam logic [7:0]  RxNack       = 8'd255;
  localparam logic [7:0]  SumFactor    = 8'd28;
  localparam logic [15:0] TimeoutMax   = 16'hFFFF;

  typedef struct packed {
    logic signed [7:0] rssi_offset;
    logic signed [7:0] rssi_floor;
    logic [3:0]        timeout_retry_limit;
    logic [3:0]        nack_retry_limit;
    logic [11:0]       start_tmo;
    logic [15:0]       rest_timeout;
    logic [7:0]        packets_per_sequence;
    logic [7:0]        total_limit;
  } cfg_t;

  typedef struct packed {
    logic timer;
    logic ack;
    logic nack;
    logic good_reply;
  } ev_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic        to_relay;
    logic [7:0]  seq_out;
    logic [7:0]  payload_sum;
    logic        timer_start;
    logic [15:0] timer_load;
    logic [1:0]  phase_out;
    logic [7:0]  ack_total;
    logic [7:0]  nack_total;
    logic        done_res;
  } res_t;

endpackage

>>> rtl/arq_chan_if.sv
// Channel interfaces for the ARQ sender: event requests in, result requests out.
// Valid/ready handshake with source and sink modports. No dependencies.
`timescale 1ns / 1ps

interface arq_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [7:0]        rx_byte;
  logic signed [7:0] raw_rssi;

  modport source (output valid, output mode, output rx_byte, output raw_rssi, input ready);
  modport sink   (input valid, input mode, input rx_byte, input raw_rssi, output ready);
endinterface

interface arq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  send_kind;
  logic        to_relay;
  logic [7:0]  seq_out;
  logic [7:0]  payload_sum;
  logic        timer_start;
  logic [15:0] timer_load;
  logic [1:0]  phase_out;
  logic [7:0]  ack_total;
  logic [7:0]  nack_total;
  logic        done_res;

  modport source (output valid, output send_kind, output to_relay, output seq_out,
                  output payload_sum, output timer_start, output timer_load,
                  output phase_out, output ack_total, output nack_total,
                  output done_res, input ready);
  modport sink   (input valid, input send_kind, input to_relay, input seq_out,
                  input payload_sum, input timer_start, input timer_load,
                  input phase_out, input ack_total, input nack_total,
                  input done_res, output ready);
endinterface

>>> rtl/arq_front.sv
// Front end: accept event requests and classify them (timer, ack, nack, strong reply).
// Depends on arq_pkg and arq_in_if.
`timescale 1ns / 1ps

module arq_front (
  arq_in_if.sink         in_ch,
  input  arq_pkg::cfg_t  cfg,
  input  logic           q_full,
  output logic           push,
  output arq_pkg::ev_t   push_ev
);
  import arq_pkg::*;

  logic signed [7:0] rssi_adj;

  assign rssi_adj    = in_ch.raw_rssi + cfg.rssi_offset;
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_ev.timer      = !in_ch.mode;
    push_ev.ack        = (in_ch.rx_byte == RxAck);
    push_ev.nack       = (in_ch.rx_byte == RxNack);
    push_ev.good_reply = (rssi_adj > cfg.rssi_floor) && rssi_adj[7];
  end

endmodule

>>> rtl/arq_queue.sv
// Short register queue between the front and back ends.
// Depends on arq_pkg.
`timescale 1ns / 1ps

module arq_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  arq_pkg::ev_t  push_ev,
  output logic          full,
  output logic          q_valid,
  output arq_pkg::ev_t  head_ev,
  input  logic          pop
);
  import arq_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  ev_t            slot_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CntW'(QueueDepth));
  assign q_valid = (cnt_r != '0);
  assign head_ev = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_ev;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop)
    else $error("queue popped while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

>>> rtl/arq_back.sv
// Back end: link state machine for probe, transmit and backoff; registers one result per event.
// Depends on arq_pkg and arq_out_if.
`timescale 1ns / 1ps

module arq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  arq_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  arq_pkg::ev_t  head_ev,
  output logic          pop,
  arq_out_if.source     out_ch
);
  import arq_pkg::*;

  phase_t      phase_r, phase_nxt;
  rx_handler_t rxh_r, rxh_nxt;
  probe_res_t  pres_r, pres_nxt;
  logic [3:0]  tret_r, tret_nxt;
  logic [3:0]  nret_r, nret_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic        relay_r, relay_nxt;
  logic        first_r, first_nxt;
  logic [15:0] tmo_r, tmo_nxt;
  logic        ackseen_r, ackseen_nxt;
  logic        nackseen_r, nackseen_nxt;
  logic [7:0]  ackc_r, ackc_nxt;
  logic [7:0]  nackc_r, nackc_nxt;
  logic [7:0]  totc_r, totc_nxt;

  logic        out_valid_r;
  res_t        res_r, res_nxt;
  send_kind_t  kind;
  logic        tstart;
  logic        done_now;
  logic [16:0] tmo_x2;
  logic [15:0] tmo_dbl;
  logic [15:0] init_tmo;

  assign pop      = q_valid && (!out_valid_r || out_ch.ready);
  assign done_now = (totc_r >= cfg.total_limit);
  assign tmo_x2   = {tmo_r, 1'b0};
  assign tmo_dbl  = tmo_x2[16] ? TimeoutMax : tmo_x2[15:0];
  assign init_tmo = 16'(cfg.start_tmo);

  always_comb begin
    phase_nxt    = phase_r;
    rxh_nxt      = rxh_r;
    pres_nxt     = pres_r;
    tret_nxt     = tret_r;
    nret_nxt     = nret_r;
    seq_nxt      = seq_r;
    relay_nxt    = relay_r;
    first_nxt    = first_r;
    tmo_nxt      = tmo_r;
    ackseen_nxt  = ackseen_r;
    nackseen_nxt = nackseen_r;
    ackc_nxt     = ackc_r;
    nackc_nxt    = nackc_r;
    totc_nxt     = totc_r;
    kind         = SK_NONE;
    tstart       = 1'b0;

    if (!done_now) begin
      if (head_ev.timer) begin
        tstart = 1'b1;
        case (phase_r)
          PH_PROBE: begin
            if (pres_r == PR_STRONG) begin
              phase_nxt = PH_TX;
              first_nxt = 1'b0;
              tret_nxt  = '0;
              tmo_nxt   = init_tmo;
            end else if (!first_r && pres_r == PR_NONE) begin
              first_nxt = 1'b1;
              kind      = SK_PROBE;
              rxh_nxt   = RH_PROBE;
            end else if (tret_r < cfg.timeout_retry_limit && pres_r == PR_NONE) begin
              tmo_nxt  = tmo_dbl;
              tret_nxt = tret_r + 1'b1;
              kind     = SK_PROBE;
              rxh_nxt  = RH_PROBE;
            end else begin
              tret_nxt = '0;
              if (relay_r) begin
                tmo_nxt   = cfg.rest_timeout;
                phase_nxt = PH_INIT;
                nackc_nxt = nackc_r + 1'b1;
                totc_nxt  = totc_r + 1'b1;
              end else begin
                tmo_nxt   = init_tmo;
                pres_nxt  = PR_NONE;
                relay_nxt = 1'b1;
              end
            end
          end
          PH_TX: begin
            rxh_nxt = RH_TX;
            if (ackseen_r) begin
              if (seq_r == cfg.packets_per_sequence) begin
                tmo_nxt   = cfg.rest_timeout;
                phase_nxt = PH_INIT;
              end else begin
                ackseen_nxt = 1'b0;
                seq_nxt     = seq_r + 1'b1;
                kind        = SK_DATA;
              end
            end else if (seq_r == 8'd1 && !first_r) begin
              first_nxt = 1'b1;
              kind      = SK_DATA;
            end else if (tret_r < cfg.timeout_retry_limit && !nackseen_r) begin
              tmo_nxt  = tmo_dbl;
              tret_nxt = tret_r + 1'b1;
              kind     = SK_DATA;
            end else if (nret_r < cfg.nack_retry_limit && nackseen_r) begin
              nret_nxt     = nret_r + 1'b1;
              nackseen_nxt = 1'b0;
              kind         = SK_DATA;
            end else begin
              ackseen_nxt  = 1'b0;
              nackseen_nxt = 1'b0;
              relay_nxt    = !relay_r;
              tret_nxt     = '0;
              nret_nxt     = '0;
              first_nxt    = 1'b0;
              tmo_nxt      = init_tmo;
              phase_nxt    = PH_PROBE;
              pres_nxt     = PR_NONE;
            end
          end
          default: begin
            tmo_nxt      = init_tmo;
            tret_nxt     = '0;
            nret_nxt     = '0;
            seq_nxt      = 8'd1;
            relay_nxt    = 1'b0;
            first_nxt    = 1'b0;
            pres_nxt     = PR_NONE;
            ackseen_nxt  = 1'b0;
            nackseen_nxt = 1'b0;
            phase_nxt    = PH_PROBE;
          end
        endcase
      end else begin
        case (rxh_r)
          RH_PROBE: begin
            pres_nxt = head_ev.good_reply ? PR_STRONG : PR_WEAK;
          end
          RH_TX: begin
            if (head_ev.ack) begin
              ackseen_nxt = 1'b1;
              ackc_nxt    = ackc_r + 1'b1;
              totc_nxt    = totc_r + 1'b1;
            end else if (head_ev.nack) begin
              nackseen_nxt = 1'b1;
              nackc_nxt    = nackc_r + 1'b1;
              totc_nxt     = totc_r + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    res_nxt             = '0;
    res_nxt.send_kind   = kind;
    res_nxt.to_relay    = (kind != SK_NONE) ? relay_nxt : 1'b0;
    res_nxt.seq_out     = (kind == SK_DATA) ? seq_nxt : 8'd0;
    res_nxt.payload_sum = (kind == SK_DATA) ? 8'(seq_nxt * SumFactor) : 8'd0;
    res_nxt.timer_start = tstart;
    res_nxt.timer_load  = tstart ? tmo_nxt : 16'd0;
    res_nxt.phase_out   = phase_nxt;
    res_nxt.ack_total   = ackc_nxt;
    res_nxt.nack_total  = nackc_nxt;
    res_nxt.done_res    = (totc_nxt >= cfg.total_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_INIT;
      rxh_r       <= RH_NONE;
      pres_r      <= PR_NONE;
      tret_r      <= '0;
      nret_r      <= '0;
      seq_r       <= 8'd1;
      relay_r     <= 1'b0;
      first_r     <= 1'b0;
      tmo_r       <= 16'd30;
      ackseen_r   <= 1'b0;
      nackseen_r  <= 1'b0;
      ackc_r      <= '0;
      nackc_r     <= '0;
      totc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r    <= phase_nxt;
        rxh_r      <= rxh_nxt;
        pres_r     <= pres_nxt;
        tret_r     <= tret_nxt;
        nret_r     <= nret_nxt;
        seq_r      <= seq_nxt;
        relay_r    <= relay_nxt;
        first_r    <= first_nxt;
        tmo_r      <= tmo_nxt;
        ackseen_r  <= ackseen_nxt;
        nackseen_r <= nackseen_nxt;
        ackc_r     <= ackc_nxt;
        nackc_r    <= nackc_nxt;
        totc_r     <= totc_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.send_kind   = res_r.send_kind;
  assign out_ch.to_relay    = res_r.to_relay;
  assign out_ch.seq_out     = res_r.seq_out;
  assign out_ch.payload_sum = res_r.payload_sum;
  assign out_ch.timer_start = res_r.timer_start;
  assign out_ch.timer_load  = res_r.timer_load;
  assign out_ch.phase_out   = res_r.phase_out;
  assign out_ch.ack_total   = res_r.ack_total;
  assign out_ch.nack_total  = res_r.nack_total;
  assign out_ch.done_res    = res_r.done_res;

  a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && done_now) |=> (res_r.send_kind == SK_NONE && !res_r.timer_start
                           && res_r.done_res))
    else $error("event past the total limit was not ignored");
  a_init_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !done_now && head_ev.timer && phase_r == PH_INIT)
    |=> (res_r.phase_out == PH_PROBE && res_r.timer_start))
    else $error("init run did not move to probe");
  a_no_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.timer_start) |-> (res_r.timer_load == 16'd0))
    else $error("timer load without timer start");
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.send_kind != SK_DATA) |-> (res_r.seq_out == 8'd0
                                                    && res_r.payload_sum == 8'd0))
    else $error("data fields set on a non-data result");

endmodule

>>> rtl/arq_sender_with_relay_fallback_unit.sv
// Stop-and-wait ARQ sender with relay fallback and exponential timeout backoff.
// Takes one timer-expiry or frame-received request per cycle while the queue is not full and
// returns one result request per event. The front end classifies each event into a two-entry
// queue; the back end runs the link state update combinationally and registers the result, so
// the sustained rate is one event per clock while the output is not stalled; an accepted event
// is written into the queue and then into the result register. A stalled output holds the
// queue, which drops input ready once both entries fill. Depends on arq_pkg, arq_chan_if,
// arq_front, arq_queue and arq_back; configuration is an APB write/read port.
`timescale 1ns / 1ps

module arq_sender_with_relay_fallback_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  arq_in_if.sink                         in_ch,
  arq_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [arq_pkg::AddrWidth-1:0]  cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import arq_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     push;
  ev_t      push_ev;
  logic     q_full;
  logic     q_valid;
  ev_t      head_ev;
  logic     pop;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[AddrWidth-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rssi_offset          <= -8'sd45;
      cfg_r.rssi_floor           <= -8'sd120;
      cfg_r.timeout_retry_limit  <= 4'd3;
      cfg_r.nack_retry_limit     <= 4'd3;
      cfg_r.start_tmo            <= 12'd30;
      cfg_r.rest_timeout         <= 16'd250;
      cfg_r.packets_per_sequence <= 8'd3;
      cfg_r.total_limit          <= 8'd100;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RSSI_OFFSET:  cfg_r.rssi_offset          <= cfg_pwdata[7:0];
        REG_RSSI_THRESH:  cfg_r.rssi_floor           <= cfg_pwdata[7:0];
        REG_TMO_LIMIT:    cfg_r.timeout_retry_limit  <= cfg_pwdata[3:0];
        REG_NACK_LIMIT:   cfg_r.nack_retry_limit     <= cfg_pwdata[3:0];
        REG_INIT_TIMEOUT: cfg_r.start_tmo            <= cfg_pwdata[11:0];
        REG_REST_TIMEOUT: cfg_r.rest_timeout         <= cfg_pwdata[15:0];
        REG_PKTS_PER_SEQ: cfg_r.packets_per_sequence <= cfg_pwdata[7:0];
        REG_TOTAL_LIMIT:  cfg_r.total_limit          <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RSSI_OFFSET:  cfg_prdata = 32'({{24{cfg_r.rssi_offset[7]}}, cfg_r.rssi_offset});
      REG_RSSI_THRESH:  cfg_prdata = 32'({{24{cfg_r.rssi_floor[7]}},
                                          cfg_r.rssi_floor});
      REG_TMO_LIMIT:    cfg_prdata = 32'(cfg_r.timeout_retry_limit);
      REG_NACK_LIMIT:   cfg_prdata = 32'(cfg_r.nack_retry_limit);
      REG_INIT_TIMEOUT: cfg_prdata = 32'(cfg_r.start_tmo);
      REG_REST_TIMEOUT: cfg_prdata = 32'(cfg_r.rest_timeout);
      REG_PKTS_PER_SEQ: cfg_prdata = 32'(cfg_r.packets_per_sequence);
      REG_TOTAL_LIMIT:  cfg_prdata = 32'(cfg_r.total_limit);
      default:          cfg_prdata = 32'd0;
    endcase
  end

  arq_front u_front (
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .push    (push),
    .push_ev (push_ev)
  );

  arq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .full    (q_full),
    .q_valid (q_valid),
    .head_ev (head_ev),
    .pop     (pop)
  );

  arq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .head_ev (head_ev),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
